@@ rtl/core/branch_next_pc_resolver_top_assert.svh @@
// Assertion macros for the branch next-PC resolver.
`ifndef BRANCH_NEXT_PC_RESOLVER_TOP_ASSERT_SVH
`define BRANCH_NEXT_PC_RESOLVER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BNPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("bnpr: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BNPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bnpr: next-cycle check failed");

`endif

@@ rtl/core/bnpr_pkg.sv @@
// Types and decode constants shared by the branch next-PC resolver.
`timescale 1ns / 1ps
package bnpr_pkg;

	// Prefix words.
	localparam logic [31:0] MASK_IMM  = 32'hffff0000;
	localparam logic [31:0] OP_IMM    = 32'hb0000000;
	localparam logic [31:0] MASK_IMML = 32'hff000000;
	localparam logic [31:0] OP_IMML   = 32'hb2000000;

	// Register-form branches.
	localparam logic [31:0] MASK_RBR  = 32'hfc0007ff;
	localparam logic [31:0] OP_BR     = 32'h98000000;
	localparam logic [31:0] OP_BRC    = 32'h9c000000;

	// Immediate-form branches and return.
	localparam logic [31:0] MASK_IBR  = 32'hfc000000;
	localparam logic [31:0] OP_RET    = 32'hb4000000;
	localparam logic [31:0] OP_BRI    = 32'hb8000000;
	localparam logic [31:0] OP_BRCI   = 32'hbc000000;

	// Condition tests, low three bits of the condition field.
	localparam logic [2:0] CC_EQ = 3'd0;
	localparam logic [2:0] CC_NE = 3'd1;
	localparam logic [2:0] CC_LT = 3'd2;
	localparam logic [2:0] CC_LE = 3'd3;
	localparam logic [2:0] CC_GT = 3'd4;
	localparam logic [2:0] CC_GE = 3'd5;

	// Immediate prefix carried alongside an instruction.
	typedef struct packed {
		logic        pending;
		logic        wide;
		logic [23:0] bits;
	} prefix_t;

	// One instruction held in the input stage.
	typedef struct packed {
		logic [63:0] pc;
		logic [31:0] ins;
		logic [63:0] ra;
		logic [63:0] rb;
		prefix_t     pfx;
	} stage_t;

endpackage

@@ rtl/core/bnpr_fetch_if.sv @@
// Request channel carrying one fetched instruction with its operands.
`timescale 1ns / 1ps
interface bnpr_fetch_if;
	logic        valid;
	logic        ready;
	logic [63:0] word_pc;
	logic [31:0] instruction;
	logic [63:0] ra_value;
	logic [63:0] rb_value;

	modport source (output valid, word_pc, instruction, ra_value, rb_value, input ready);
	modport sink (input valid, word_pc, instruction, ra_value, rb_value, output ready);
endinterface

@@ rtl/core/bnpr_redirect_if.sv @@
// Request channel carrying one resolved next program counter.
`timescale 1ns / 1ps
interface bnpr_redirect_if;
	logic        valid;
	logic        ready;
	logic [63:0] next_pc;

	modport source (output valid, next_pc, input ready);
	modport sink (input valid, next_pc, output ready);
endinterface

@@ rtl/core/bnpr_prefix.sv @@
// Immediate prefix tracker: detects IMM/IMML words and holds their bits.
`timescale 1ns / 1ps
module bnpr_prefix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [31:0]        instruction,
	output logic               is_prefix,
	output bnpr_pkg::prefix_t  snap
);
	import bnpr_pkg::*;

	logic        pend_q;
	logic        wide_q;
	logic [23:0] bits_q;
	logic        is_imm;
	logic        is_imml;

	// A prefix counts as such only when no prefix is already pending.
	assign is_imm    = !pend_q && ((instruction & MASK_IMM) == OP_IMM);
	assign is_imml   = !pend_q && ((instruction & MASK_IMML) == OP_IMML);
	assign is_prefix = is_imm || is_imml;

	// The state seen by the current word travels with it.
	assign snap.pending = pend_q;
	assign snap.wide    = wide_q;
	assign snap.bits    = bits_q;

	// Store a new prefix; any other accepted word consumes the pending one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			wide_q <= 1'b0;
			bits_q <= '0;
		end else if (accept) begin
			if (is_imm) begin
				pend_q <= 1'b1;
				wide_q <= 1'b0;
				bits_q <= {8'd0, instruction[15:0]};
			end else if (is_imml) begin
				pend_q <= 1'b1;
				wide_q <= 1'b1;
				bits_q <= instruction[23:0];
			end else begin
				pend_q <= 1'b0;
				wide_q <= 1'b0;
				bits_q <= '0;
			end
		end
	end
endmodule

@@ rtl/core/bnpr_target.sv @@
// Next-PC computation for one staged instruction: decode, condition, one adder.
`timescale 1ns / 1ps
module bnpr_target (
	input  bnpr_pkg::stage_t stage,
	output logic [63:0]      next_pc
);
	import bnpr_pkg::*;

	logic [31:0] ins;
	logic [63:0] ra;
	logic [63:0] rb;
	logic [63:0] imm;
	logic        z32;
	logic        n32;
	logic        z64;
	logic        n64;
	logic        zf;
	logic        nf;
	logic        taken;
	logic        delay;
	logic        absolute;
	logic [63:0] step;
	logic [63:0] base;
	logic [63:0] offset;

	assign ins      = stage.ins;
	assign delay    = ins[25];
	assign absolute = ins[19];

	// Register index zero reads as zero.
	assign ra = (ins[20:16] == 5'd0) ? 64'd0 : stage.ra;
	assign rb = (ins[15:11] == 5'd0) ? 64'd0 : stage.rb;

	// Sign-extended immediate, widened by a pending prefix.
	always_comb begin
		if (!stage.pfx.pending) begin
			imm = {{48{ins[15]}}, ins[15:0]};
		end else if (stage.pfx.wide) begin
			imm = {{24{stage.pfx.bits[23]}}, stage.pfx.bits, ins[15:0]};
		end else begin
			imm = {{32{stage.pfx.bits[15]}}, stage.pfx.bits[15:0], ins[15:0]};
		end
	end

	// Signed tests against zero on the low word or the whole register.
	assign z32 = (ra[31:0] == 32'd0);
	assign n32 = ra[31];
	assign z64 = (ra == 64'd0);
	assign n64 = ra[63];
	assign zf  = ins[24] ? z64 : z32;
	assign nf  = ins[24] ? n64 : n32;

	always_comb begin
		unique case (ins[23:21])
			CC_EQ:   taken = zf;
			CC_NE:   taken = !zf;
			CC_LT:   taken = nf;
			CC_LE:   taken = nf || zf;
			CC_GT:   taken = !nf && !zf;
			CC_GE:   taken = !nf;
			default: taken = 1'b0;
		endcase
	end

	// Fall-through step; a not-taken branch with a delay slot skips the slot.
	assign step = delay ? 64'd8 : 64'd4;

	// Pick the two adder operands for the instruction class.
	always_comb begin
		base   = stage.pc;
		offset = 64'd4;
		if ((ins & MASK_RBR) == OP_BR) begin
			base   = absolute ? 64'd0 : stage.pc;
			offset = rb;
		end else if ((ins & MASK_RBR) == OP_BRC) begin
			offset = taken ? rb : step;
		end else if ((ins & MASK_IBR) == OP_RET) begin
			base   = ra;
			offset = imm;
		end else if ((ins & MASK_IBR) == OP_BRI) begin
			base   = absolute ? 64'd0 : stage.pc;
			offset = imm;
		end else if ((ins & MASK_IBR) == OP_BRCI) begin
			offset = taken ? imm : step;
		end
	end

	// Single wrapping 64-bit add.
	assign next_pc = base + offset;
endmodule

@@ rtl/core/branch_next_pc_resolver_top.sv @@
// A non-prefix request is registered into the input stage at its accepting edge; its next PC
// moves into the result register when the stage advances, and is then presented on redirect.
// One request per cycle while redirect is ready, set by the input stage and result register.
// Prefix requests are absorbed by the prefix tracker and give no result.
// Reset (arst_n low) empties both registers and clears any pending prefix.
// Delivery follows request order; a stalled result blocks the input once the stage is full.
`timescale 1ns / 1ps
module branch_next_pc_resolver_top (
	input  logic  clk,
	input  logic  arst_n,
	bnpr_fetch_if.sink      fetch,
	bnpr_redirect_if.source redirect
);
	import bnpr_pkg::*;

	`include "branch_next_pc_resolver_top_assert.svh"

	logic        accept;
	logic        is_prefix;
	prefix_t     snap;
	stage_t      stage_s1;
	logic        valid_s1;
	logic        advance;
	logic [63:0] target;
	logic [63:0] next_pc_q;
	logic        out_valid_q;

	// Handshake: the input stage frees up whenever its item moves on.
	assign advance      = valid_s1 && (!out_valid_q || redirect.ready);
	assign fetch.ready  = !valid_s1 || advance;
	assign accept       = fetch.valid && fetch.ready;

	bnpr_prefix u_prefix (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.instruction (fetch.instruction),
		.is_prefix   (is_prefix),
		.snap        (snap)
	);

	bnpr_target u_target (
		.stage   (stage_s1),
		.next_pc (target)
	);

	// Control: stage and result valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fetch.ready) begin
				valid_s1 <= accept && !is_prefix;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (redirect.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: input stage and result register.
	always_ff @(posedge clk) begin
		if (accept && !is_prefix) begin
			stage_s1.pc  <= fetch.word_pc;
			stage_s1.ins <= fetch.instruction;
			stage_s1.ra  <= fetch.ra_value;
			stage_s1.rb  <= fetch.rb_value;
			stage_s1.pfx <= snap;
		end
		if (advance) begin
			next_pc_q <= target;
		end
	end

	assign redirect.valid   = out_valid_q;
	assign redirect.next_pc = next_pc_q;

	// A prefix request never reaches the input stage.
	`BNPR_ASSERT_NXT(a_prefix_absorbed, clk, arst_n, accept && is_prefix, !valid_s1)
	// An accepted prefix is pending for the following request.
	`BNPR_ASSERT_NXT(a_prefix_held, clk, arst_n, accept && is_prefix, snap.pending)
	// Any other accepted request consumes the pending prefix.
	`BNPR_ASSERT_NXT(a_prefix_used, clk, arst_n, accept && !is_prefix, !snap.pending)
	// A result only appears after the input stage handed one over.
	`BNPR_ASSERT_IMP(a_out_from_stage, clk, arst_n, $rose(out_valid_q), $past(valid_s1))
endmodule
